@@ rtl/tfn_pkg.sv @@
package tfn_pkg;

    localparam int CoordWidth  = 16;
    localparam int NormalWidth = 16;
    localparam int FracBits    = NormalWidth - 2;
    localparam int EdgeWidth   = CoordWidth + 1;
    localparam int ProdWidth   = 2 * EdgeWidth;
    localparam int CrossWidth  = ProdWidth + 1;
    localparam int MagWidth    = CrossWidth - 1;
    localparam int SqWidth     = 2 * MagWidth;
    localparam int AccWidth    = SqWidth + 2 * FracBits + 8;
    localparam int Steps       = FracBits + 1;
    localparam int MWidth      = FracBits + 1;
    localparam int PosWidth    = $clog2(Steps);
    localparam int Lanes       = 3;

    typedef logic signed [AccWidth-1:0] t_acc;

    typedef struct packed {
        t_acc              e;
        t_acc              p;
        logic [MWidth-1:0] m;
        logic              neg;
    } t_lane;

    typedef struct packed {
        t_acc                  s;
        t_lane [Lanes-1:0]     lane;
        logic                  degen;
    } t_stage;

endpackage

@@ rtl/tfn_step.sv @@
module tfn_step (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [tfn_pkg::PosWidth-1:0]  i_bit_pos,
    input  tfn_pkg::t_stage               i_data,
    output logic                          o_valid,
    output tfn_pkg::t_stage               o_data
);

    logic            r_valid;
    tfn_pkg::t_stage r_data;
    tfn_pkg::t_stage n_data;
    tfn_pkg::t_acc   d [tfn_pkg::Lanes];

    // one result bit per lane: grow (2m-1)^2 * s against the target with shifts only
    always_comb begin
        n_data = i_data;
        for (int l = 0; l < tfn_pkg::Lanes; l++) begin
            d[l] = (i_data.lane[l].p <<< (i_bit_pos + 2))
                 + (i_data.s <<< (2 * i_bit_pos + 2));
            if (d[l] <= i_data.lane[l].e) begin
                n_data.lane[l].e = i_data.lane[l].e - d[l];
                n_data.lane[l].p = i_data.lane[l].p + (i_data.s <<< (i_bit_pos + 1));
                n_data.lane[l].m[i_bit_pos] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/triangle_face_normal.sv @@
// an item passes edge, product, cross, square and seed registers, the steps, then the output register
// throughput: one item per cycle while the output is not stalled; 15 bit-decision stages set the depth
// the whole pipeline holds while the output item is stalled
// reset: synchronous active-low i_rst_n clears all valid bits; data is not reset
module triangle_face_normal (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic signed [tfn_pkg::CoordWidth-1:0]   i_ax,
    input  logic signed [tfn_pkg::CoordWidth-1:0]   i_ay,
    input  logic signed [tfn_pkg::CoordWidth-1:0]   i_az,
    input  logic signed [tfn_pkg::CoordWidth-1:0]   i_bx,
    input  logic signed [tfn_pkg::CoordWidth-1:0]   i_by,
    input  logic signed [tfn_pkg::CoordWidth-1:0]   i_bz,
    input  logic signed [tfn_pkg::CoordWidth-1:0]   i_cx,
    input  logic signed [tfn_pkg::CoordWidth-1:0]   i_cy,
    input  logic signed [tfn_pkg::CoordWidth-1:0]   i_cz,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic signed [tfn_pkg::NormalWidth-1:0]  o_normal_x,
    output logic signed [tfn_pkg::NormalWidth-1:0]  o_normal_y,
    output logic signed [tfn_pkg::NormalWidth-1:0]  o_normal_z,
    output logic                                    o_degenerate
);

    localparam int EW = tfn_pkg::EdgeWidth;
    localparam int PW = tfn_pkg::ProdWidth;
    localparam int CW = tfn_pkg::CrossWidth;
    localparam int MW = tfn_pkg::MagWidth;
    localparam int SW = tfn_pkg::SqWidth;
    localparam int NW = tfn_pkg::NormalWidth;
    localparam int NL = tfn_pkg::Lanes;

    logic en;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_out_valid;

    logic signed [EW-1:0] r_ux, r_uy, r_uz, r_vx, r_vy, r_vz;
    logic signed [PW-1:0] r_prod [6];
    logic signed [CW-1:0] r_n [NL];
    logic signed [CW-1:0] n_abs [NL];
    logic [SW-1:0]        r_sq [NL];
    logic                 r_neg [NL];
    tfn_pkg::t_stage      r_st5;
    tfn_pkg::t_stage      n_st5;
    tfn_pkg::t_acc        sum;

    logic                 sv [tfn_pkg::Steps+1];
    tfn_pkg::t_stage      sd [tfn_pkg::Steps+1];

    logic signed [NW-1:0] n_norm [NL];
    logic signed [NW-1:0] r_norm [NL];
    logic                 r_degen;

    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_v1        <= i_valid;
            r_v2        <= r_v1;
            r_v3        <= r_v2;
            r_v4        <= r_v3;
            r_v5        <= r_v4;
            r_out_valid <= sv[tfn_pkg::Steps];
        end
    end

    // edges, products, cross terms, squares, and the squared-length sum that seeds the bit-decision stages
    always_comb begin
        for (int l = 0; l < NL; l++) begin
            n_abs[l] = r_n[l][CW-1] ? -r_n[l] : r_n[l];
        end
        sum = tfn_pkg::t_acc'(r_sq[0]) + tfn_pkg::t_acc'(r_sq[1])
            + tfn_pkg::t_acc'(r_sq[2]);
        n_st5.s     = sum;
        n_st5.degen = (sum == '0);
        for (int l = 0; l < NL; l++) begin
            n_st5.lane[l].e   = (tfn_pkg::t_acc'(r_sq[l]) <<< (2 * tfn_pkg::FracBits + 2))
                              - sum;
            n_st5.lane[l].p   = -sum;
            n_st5.lane[l].m   = '0;
            n_st5.lane[l].neg = r_neg[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ux <= EW'(i_bx) - EW'(i_ax);
            r_uy <= EW'(i_by) - EW'(i_ay);
            r_uz <= EW'(i_bz) - EW'(i_az);
            r_vx <= EW'(i_cx) - EW'(i_ax);
            r_vy <= EW'(i_cy) - EW'(i_ay);
            r_vz <= EW'(i_cz) - EW'(i_az);
            r_prod[0] <= PW'(r_uy) * PW'(r_vz);
            r_prod[1] <= PW'(r_uz) * PW'(r_vy);
            r_prod[2] <= PW'(r_uz) * PW'(r_vx);
            r_prod[3] <= PW'(r_ux) * PW'(r_vz);
            r_prod[4] <= PW'(r_ux) * PW'(r_vy);
            r_prod[5] <= PW'(r_uy) * PW'(r_vx);
            for (int l = 0; l < NL; l++) begin
                r_n[l]   <= CW'(r_prod[2*l]) - CW'(r_prod[2*l+1]);
                r_neg[l] <= r_n[l][CW-1];
                r_sq[l]  <= SW'(n_abs[l][MW-1:0]) * SW'(n_abs[l][MW-1:0]);
            end
            r_st5 <= n_st5;
        end
    end

    assign sv[0] = r_v5;
    assign sd[0] = r_st5;

    for (genvar k = 0; k < tfn_pkg::Steps; k++) begin : g_step
        tfn_step u_step (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (en),
            .i_valid   (sv[k]),
            .i_bit_pos (tfn_pkg::PosWidth'(tfn_pkg::FracBits - k)),
            .i_data    (sd[k]),
            .o_valid   (sv[k+1]),
            .o_data    (sd[k+1])
        );
    end

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            if (sd[tfn_pkg::Steps].degen) begin
                n_norm[l] = '0;
            end else if (sd[tfn_pkg::Steps].lane[l].neg) begin
                n_norm[l] = -NW'(sd[tfn_pkg::Steps].lane[l].m);
            end else begin
                n_norm[l] = NW'(sd[tfn_pkg::Steps].lane[l].m);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < NL; l++) begin
                r_norm[l] <= n_norm[l];
            end
            r_degen <= sd[tfn_pkg::Steps].degen;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_normal_x   = r_norm[0];
    assign o_normal_y   = r_norm[1];
    assign o_normal_z   = r_norm[2];
    assign o_degenerate = r_degen;

endmodule
